// ===== rtl/swaa_pkg.sv =====
package swaa_pkg;

  // Command codes of an input word.
  localparam logic [1:0] CMD_SEND    = 2'd0;
  localparam logic [1:0] CMD_INBOUND = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  // Inbound frame kinds.
  localparam logic [1:0] KIND_EVENT = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;

  // Outbound frame kinds.
  localparam logic FRAME_EVENT = 1'b0;
  localparam logic FRAME_ACK   = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ROLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ID_VALID       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_TIMEOUT   = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd2;
  localparam logic [7:0]  RETRY_LIMIT_RST    = 8'd3;
  localparam logic [31:0] DROP_TIMEOUT_RST   = 32'd10;

  typedef struct packed {
    logic [7:0]  node_role;
    logic        id_valid;
    logic [31:0] retry_interval;
    logic [7:0]  retry_limit;
    logic [31:0] drop_timeout;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now;
    logic [1:0]  in_kind;
    logic [31:0] in_stamp;
    logic [31:0] event_stamp;
    logic [63:0] event_data;
    logic        push_ok;
  } item_t;

  typedef struct packed {
    logic        accepted;
    logic        frame_valid;
    logic        frame_kind;
    logic [31:0] frame_stamp;
    logic [31:0] frame_event_stamp;
    logic [63:0] frame_event_data;
    logic        deliver_valid;
    logic        last_acked;
    logic        pending_busy;
  } result_t;

endpackage

// ===== rtl/swaa_cfg.sv =====
module swaa_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [swaa_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [31:0]                      wr_data,
  output swaa_pkg::cfg_t                   cfg
);

  swaa_pkg::cfg_t cfg_r;
  swaa_pkg::cfg_t cfg_nxt;

  // Decode the register index and update the addressed field.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        swaa_pkg::REG_NODE_ROLE:      cfg_nxt.node_role      = wr_data[7:0];
        swaa_pkg::REG_ID_VALID:       cfg_nxt.id_valid       = wr_data[0];
        swaa_pkg::REG_RETRY_INTERVAL: cfg_nxt.retry_interval = wr_data;
        swaa_pkg::REG_RETRY_LIMIT:    cfg_nxt.retry_limit    = wr_data[7:0];
        swaa_pkg::REG_DROP_TIMEOUT:   cfg_nxt.drop_timeout   = wr_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_role      <= 8'd0;
      cfg_r.id_valid       <= 1'b0;
      cfg_r.retry_interval <= swaa_pkg::RETRY_INTERVAL_RST;
      cfg_r.retry_limit    <= swaa_pkg::RETRY_LIMIT_RST;
      cfg_r.drop_timeout   <= swaa_pkg::DROP_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/swaa_core.sv =====
module swaa_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  swaa_pkg::item_t  item,
  input  swaa_pkg::cfg_t   cfg,
  output swaa_pkg::result_t res
);

  // Pending event state.
  logic        pending_flag_r, pending_flag_nxt;
  logic        acked_flag_r, acked_flag_nxt;
  logic [31:0] pending_stamp_r, pending_stamp_nxt;
  logic [63:0] pending_data_r, pending_data_nxt;
  logic [31:0] attempt_time_r, attempt_time_nxt;
  logic [7:0]  retry_count_r, retry_count_nxt;

  logic [31:0] gap;
  logic        retry_due;
  logic        retries_left;
  logic        drop_due;

  // Elapsed time since the last attempt, clamped at zero.
  assign gap          = (item.now > attempt_time_r) ? (item.now - attempt_time_r) : 32'd0;
  assign retry_due    = (gap >= cfg.retry_interval);
  assign retries_left = (retry_count_r < cfg.retry_limit);
  assign drop_due     = (gap >= cfg.drop_timeout);

  // One pass over the command: result word and next state.
  always_comb begin
    pending_flag_nxt  = pending_flag_r;
    acked_flag_nxt    = acked_flag_r;
    pending_stamp_nxt = pending_stamp_r;
    pending_data_nxt  = pending_data_r;
    attempt_time_nxt  = attempt_time_r;
    retry_count_nxt   = retry_count_r;
    res               = '0;

    case (item.cmd)
      swaa_pkg::CMD_SEND: begin
        if (cfg.id_valid && item.push_ok) begin
          res.accepted          = 1'b1;
          res.frame_valid       = 1'b1;
          res.frame_kind        = swaa_pkg::FRAME_EVENT;
          res.frame_stamp       = item.now;
          res.frame_event_stamp = item.event_stamp;
          res.frame_event_data  = item.event_data;
          pending_stamp_nxt     = item.event_stamp;
          pending_data_nxt      = item.event_data;
          attempt_time_nxt      = item.now;
          retry_count_nxt       = 8'd0;
          pending_flag_nxt      = 1'b1;
          acked_flag_nxt        = 1'b0;
        end
      end
      swaa_pkg::CMD_INBOUND: begin
        if (item.in_kind == swaa_pkg::KIND_ACK) begin
          if (pending_flag_r && (item.in_stamp == pending_stamp_r)) begin
            pending_flag_nxt = 1'b0;
            acked_flag_nxt   = 1'b1;
          end
        end else if (item.in_kind == swaa_pkg::KIND_EVENT) begin
          res.accepted          = 1'b1;
          res.deliver_valid     = 1'b1;
          res.frame_event_stamp = item.event_stamp;
          res.frame_event_data  = item.event_data;
          if (item.push_ok) begin
            res.frame_valid = 1'b1;
            res.frame_kind  = swaa_pkg::FRAME_ACK;
            res.frame_stamp = item.event_stamp;
          end
        end
      end
      swaa_pkg::CMD_TICK: begin
        if (pending_flag_r && retry_due) begin
          if (retries_left) begin
            if (item.push_ok) begin
              res.accepted          = 1'b1;
              res.frame_valid       = 1'b1;
              res.frame_kind        = swaa_pkg::FRAME_EVENT;
              res.frame_stamp       = item.now;
              res.frame_event_stamp = pending_stamp_r;
              res.frame_event_data  = pending_data_r;
              retry_count_nxt       = retry_count_r + 8'd1;
              attempt_time_nxt      = item.now;
            end
          end else if (drop_due) begin
            pending_flag_nxt = 1'b0;
            acked_flag_nxt   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    res.last_acked   = acked_flag_nxt;
    res.pending_busy = pending_flag_nxt;
  end

  // Flags need reset; the stored event is only read while pending.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_flag_r <= 1'b0;
      acked_flag_r   <= 1'b0;
    end else if (fire) begin
      pending_flag_r <= pending_flag_nxt;
      acked_flag_r   <= acked_flag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pending_stamp_r <= pending_stamp_nxt;
      pending_data_r  <= pending_data_nxt;
      attempt_time_r  <= attempt_time_nxt;
      retry_count_r   <= retry_count_nxt;
    end
  end

endmodule

// ===== rtl/stop_and_wait_ack_retry.sv =====
// Channel  Handshake            Payload
// in_      in_valid / in_stall  cmd, now, kind, stamp, event stamp/data, push_ok
// out_     out_valid / out_stall one result word per input word
// cfg_     cfg_valid / cfg_ready register index and 32-bit write data
//
// One input word is taken every cycle while in_stall is low; it passes through the input register
// and then the result register before its result is valid on out_.
// The event state updates as the word moves into the result register, so
// words follow one another with no gap.
// Reset is synchronous on rst_n; no memory sweep.
// out_stall holds the result register and raises in_stall once the input register is full.
module stop_and_wait_ack_retry (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swaa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  // Input channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_cmd,
  input  logic [31:0]                    in_now,
  input  logic [1:0]                     in_kind,
  input  logic [31:0]                    in_stamp,
  input  logic [31:0]                    in_event_stamp,
  input  logic [63:0]                    in_event_data,
  input  logic                           in_push_ok,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_accepted,
  output logic                           out_frame_valid,
  output logic                           out_frame_kind,
  output logic [31:0]                    out_frame_stamp,
  output logic [31:0]                    out_frame_event_stamp,
  output logic [63:0]                    out_frame_event_data,
  output logic                           out_deliver_valid,
  output logic                           out_last_acked,
  output logic                           out_pending_busy
);

  swaa_pkg::cfg_t    cfg;
  swaa_pkg::item_t   item_r;
  swaa_pkg::result_t res;
  swaa_pkg::result_t res_r;

  logic item_valid_r, item_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic advance;
  logic take_in;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  swaa_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: a word moves on when the result register is free or draining.
  assign advance  = item_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = item_valid_r && !advance;
  assign take_in  = in_valid && !in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (take_in) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (take_in) begin
      item_r.cmd         <= in_cmd;
      item_r.now         <= in_now;
      item_r.in_kind     <= in_kind;
      item_r.in_stamp    <= in_stamp;
      item_r.event_stamp <= in_event_stamp;
      item_r.event_data  <= in_event_data;
      item_r.push_ok     <= in_push_ok;
    end
  end

  // Protocol logic and pending event state.
  swaa_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_accepted          = res_r.accepted;
  assign out_frame_valid       = res_r.frame_valid;
  assign out_frame_kind        = res_r.frame_kind;
  assign out_frame_stamp       = res_r.frame_stamp;
  assign out_frame_event_stamp = res_r.frame_event_stamp;
  assign out_frame_event_data  = res_r.frame_event_data;
  assign out_deliver_valid     = res_r.deliver_valid;
  assign out_last_acked        = res_r.last_acked;
  assign out_pending_busy      = res_r.pending_busy;

endmodule
